FILE: hw/rtl/crcdf_pkg.sv
`default_nettype none

package crcdf_pkg;

  // CRC-16/MCRF4XX: reflected polynomial, all-ones start, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // configuration register indexes
  localparam logic [1:0] CFG_AUTO_ACK  = 2'd0;
  localparam logic [1:0] CFG_START     = 2'd1;
  localparam logic [1:0] CFG_SEQ_TYPE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam logic [6:0] LEN_SAT = 7'd127;

  // controller to datapath, all qualified by an accepted item except emit
  typedef struct packed {
    logic crc_init;
    logic take_type;
    logic take_len_lo;
    logic take_len_hi;
    logic take_body;
    logic take_crc_lo;
    logic check_crc;
    logic emit;
  } crcdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic len_big;
    logic len_zero;
    logic body_last;
    logic crc_ok;
    logic frame_empty;
    logic emit_done;
    logic out_free;
  } crcdf_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crcdf_ram.sv
`default_nettype none

module crcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crcdf_ctrl.sv
`default_nettype none

module crcdf_ctrl
  import crcdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire crcdf_sts_t sts,
  output crcdf_cmd_t      cmd
);

  localparam logic [2:0] S_HUNT   = 3'd0;
  localparam logic [2:0] S_TYPE   = 3'd1;
  localparam logic [2:0] S_LEN_LO = 3'd2;
  localparam logic [2:0] S_LEN_HI = 3'd3;
  localparam logic [2:0] S_BODY   = 3'd4;
  localparam logic [2:0] S_CRC_LO = 3'd5;
  localparam logic [2:0] S_CRC_HI = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  // bytes that may post a result wait for a free output register
  always_comb begin
    case (state_r)
      S_EMIT:             in_ready = 1'b0;
      S_LEN_HI, S_CRC_HI: in_ready = sts.out_free;
      default:            in_ready = 1'b1;
    endcase
  end

  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (acc && sts.is_start) begin
          cmd.crc_init = 1'b1;
          state_nxt    = S_TYPE;
        end
      end
      S_TYPE: begin
        if (acc) begin
          cmd.take_type = 1'b1;
          state_nxt     = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (acc) begin
          cmd.take_len_lo = 1'b1;
          state_nxt       = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        if (acc) begin
          cmd.take_len_hi = 1'b1;
          if (sts.len_big) begin
            state_nxt = S_HUNT;
          end else if (sts.len_zero) begin
            state_nxt = S_CRC_LO;
          end else begin
            state_nxt = S_BODY;
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          cmd.take_body = 1'b1;
          if (sts.body_last) begin
            state_nxt = S_CRC_LO;
          end
        end
      end
      S_CRC_LO: begin
        if (acc) begin
          cmd.take_crc_lo = 1'b1;
          state_nxt       = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (acc) begin
          cmd.check_crc = 1'b1;
          state_nxt     = (sts.crc_ok && !sts.frame_empty) ? S_EMIT : S_HUNT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) begin
          state_nxt = S_HUNT;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    sts.emit_done |-> state_r == S_EMIT)
    else $error("emit_done outside the emit phase");

endmodule

`default_nettype wire

FILE: hw/rtl/crcdf_dp.sv
`default_nettype none

module crcdf_dp
  import crcdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic [7:0] rx_byte,
  input  wire crcdf_cmd_t cmd,
  output crcdf_sts_t      sts,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic      [1:0] out_status,
  output logic      [7:0] out_frame_type,
  output logic      [6:0] out_frame_length,
  output logic      [5:0] out_byte_index,
  output logic      [7:0] out_payload_byte,
  output logic            out_last,
  output logic            out_ack_request,
  output logic      [7:0] out_ack_sequence
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0]  MAXP   = 7'(MAX_PAYLOAD);
  localparam logic [15:0] MAXP16 = 16'(MAX_PAYLOAD);

  // configuration
  logic       ack_cfg_r;
  logic [7:0] start_cfg_r;
  logic [7:0] seq_type_cfg_r;

  // frame state
  logic [7:0]  type_r;
  logic [7:0]  len_lo_r;
  logic [6:0]  len_r;
  logic [6:0]  cnt_r;
  logic [7:0]  crc_lo_r;
  logic [15:0] crc_r;
  logic [7:0]  byte0_r;

  // emission
  logic [6:0] rd_cnt_r;
  logic       pend_r;
  logic [5:0] pend_idx_r;
  logic [7:0] rd_data;
  logic       rd_en;
  logic       load;
  logic       load_last;
  logic       out_free;

  // output register
  logic       o_valid_r;
  logic [1:0] o_status_r;
  logic [7:0] o_type_r;
  logic [6:0] o_len_r;
  logic [5:0] o_idx_r;
  logic [7:0] o_pb_r;
  logic       o_last_r;
  logic       o_ack_r;
  logic [7:0] o_seq_r;

  logic [15:0] full_len;
  logic [6:0]  cnt_inc;
  logic [6:0]  sat_len;
  logic        wr_en;
  logic        post;
  logic [1:0]  p_status;
  logic [6:0]  p_len;
  logic [5:0]  p_idx;
  logic [7:0]  p_pb;
  logic        p_ack;
  logic [7:0]  p_seq;
  logic [7:0]  seq_val;

  assign full_len = {rx_byte, len_lo_r};
  assign cnt_inc  = cnt_r + 7'd1;
  assign sat_len  = (rx_byte != 8'h00 || len_lo_r[7]) ? LEN_SAT : len_lo_r[6:0];
  assign out_free = !o_valid_r || out_ready;
  assign seq_val  = (type_r == seq_type_cfg_r) ? byte0_r : 8'h00;

  assign sts.is_start    = rx_byte == start_cfg_r;
  assign sts.len_big     = full_len > MAXP16;
  assign sts.len_zero    = full_len == 16'h0000;
  assign sts.body_last   = cnt_inc >= len_r;
  assign sts.crc_ok      = {rx_byte, crc_lo_r} == crc_r;
  assign sts.frame_empty = len_r == 7'd0;
  assign sts.emit_done   = load && load_last;
  assign sts.out_free    = out_free;

  assign wr_en = cmd.take_body && (cnt_r < MAXP);

  // hold read data in the RAM register until the output register takes it
  assign load      = pend_r && out_free;
  assign load_last = ({1'b0, pend_idx_r} + 7'd1) == len_r;
  assign rd_en     = cmd.emit && (rd_cnt_r < len_r) && (!pend_r || load);

  crcdf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(rx_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_cnt_r[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_cfg_r      <= 1'b0;
      start_cfg_r    <= 8'hA5;
      seq_type_cfg_r <= 8'h01;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_AUTO_ACK: ack_cfg_r      <= cfg_wdata[0];
        CFG_START:    start_cfg_r    <= cfg_wdata;
        CFG_SEQ_TYPE: seq_type_cfg_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= 8'h00;
      len_lo_r <= 8'h00;
      len_r    <= 7'd0;
      cnt_r    <= 7'd0;
      crc_lo_r <= 8'h00;
      crc_r    <= CRC_INIT;
    end else begin
      if (cmd.crc_init) begin
        crc_r <= CRC_INIT;
      end
      if (cmd.take_type || cmd.take_len_lo || cmd.take_len_hi || cmd.take_body) begin
        crc_r <= crc_byte(crc_r, rx_byte);
      end
      if (cmd.take_type) begin
        type_r <= rx_byte;
      end
      if (cmd.take_len_lo) begin
        len_lo_r <= rx_byte;
      end
      if (cmd.take_len_hi) begin
        len_r <= len_lo_r[6:0];
        cnt_r <= 7'd0;
      end
      if (cmd.take_body) begin
        cnt_r <= cnt_inc;
      end
      if (cmd.take_crc_lo) begin
        crc_lo_r <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_body && cnt_r == 7'd0) begin
      byte0_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= 7'd0;
      pend_r     <= 1'b0;
      pend_idx_r <= 6'd0;
    end else begin
      if (cmd.check_crc) begin
        rd_cnt_r <= 7'd0;
      end
      if (rd_en) begin
        rd_cnt_r   <= rd_cnt_r + 7'd1;
        pend_r     <= 1'b1;
        pend_idx_r <= rd_cnt_r[5:0];
      end else if (load) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_comb begin
    post     = 1'b0;
    p_status = ST_DATA;
    p_len    = 7'd0;
    p_idx    = 6'd0;
    p_pb     = 8'h00;
    p_ack    = 1'b0;
    p_seq    = 8'h00;
    if (cmd.take_len_hi && sts.len_big) begin
      post     = 1'b1;
      p_status = ST_TOO_LONG;
      p_len    = sat_len;
    end else if (cmd.check_crc && !sts.crc_ok) begin
      post     = 1'b1;
      p_status = ST_CRC_BAD;
      p_len    = len_r;
    end else if (cmd.check_crc && sts.frame_empty) begin
      post     = 1'b1;
      p_status = ST_EMPTY;
      p_ack    = ack_cfg_r;
    end else if (load) begin
      post     = 1'b1;
      p_status = ST_DATA;
      p_len    = len_r;
      p_idx    = pend_idx_r;
      p_pb     = rd_data;
      p_ack    = ack_cfg_r;
      p_seq    = seq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (post) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      o_status_r <= p_status;
      o_type_r   <= type_r;
      o_len_r    <= p_len;
      o_idx_r    <= p_idx;
      o_pb_r     <= p_pb;
      o_last_r   <= (p_status != ST_DATA) || load_last;
      o_ack_r    <= p_ack;
      o_seq_r    <= p_seq;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_status       = o_status_r;
  assign out_frame_type   = o_type_r;
  assign out_frame_length = o_len_r;
  assign out_byte_index   = o_idx_r;
  assign out_payload_byte = o_pb_r;
  assign out_last         = o_last_r;
  assign out_ack_request  = o_ack_r;
  assign out_ack_sequence = o_seq_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cmd.emit)
    else $error("payload result loaded outside emission");

  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.emit |-> !pend_r)
    else $error("store read pending outside emission");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_len_hi || cmd.check_crc) |-> out_free)
    else $error("result posted over an occupied output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> rd_cnt_r <= len_r)
    else $error("store read beyond frame length");

endmodule

`default_nettype wire

FILE: hw/rtl/crc16_frame_deframer.sv
`default_nettype none

// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   in_tdata: one received link byte
// out_      out  out_tvalid/out_tready out_tdata, out_tuser (status), out_tlast
// cfg_      in   cfg_wr_en             cfg_index, cfg_wdata (no read-back)
//
// Cycles: one byte item per cycle while hunting and inside a frame. The high
// length byte and the high CRC byte wait until the output register is free.
// A good frame of N payload bytes streams N results from the payload RAM,
// one per cycle after a registered read; input is held meanwhile.
// Reset: synchronous, active low; the payload RAM needs no clearing pass.
// Stalls: out_tready low holds the output register and the pending RAM read.
module crc16_frame_deframer
  import crcdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // received byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] frame_type, [14:8] frame_length, [20:15] byte_index,
  // [28:21] payload_byte, [29] ack_request, [37:30] ack_sequence, [39:38] zero
  output logic      [39:0] out_tdata,
  output logic      [1:0]  out_tuser,  // [1:0] status
  output logic             out_tlast
);

  crcdf_cmd_t cmd;
  crcdf_sts_t sts;

  logic [6:0] frame_length;
  logic [5:0] byte_index;
  logic [7:0] frame_type;
  logic [7:0] payload_byte;
  logic [7:0] ack_sequence;
  logic       ack_request;

  // sequencer: hunt, header, body, crc, then emission of a good frame
  crcdf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // CRC, length checks, payload RAM and output register
  crcdf_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .rx_byte         (in_tdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (out_tuser),
    .out_frame_type  (frame_type),
    .out_frame_length(frame_length),
    .out_byte_index  (byte_index),
    .out_payload_byte(payload_byte),
    .out_last        (out_tlast),
    .out_ack_request (ack_request),
    .out_ack_sequence(ack_sequence)
  );

  // pack result fields, first field lowest
  assign out_tdata = {2'b00, ack_sequence, ack_request, payload_byte,
                      byte_index, frame_length, frame_type};

endmodule

`default_nettype wire
